// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

// Checks that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// ----- hdl/mhu_pkg.sv -----
// Package with types, character codes and limits of the MIME header unfolder.
package mhu_pkg;

  localparam int unsigned MaxHeaderBytesDef = 1024;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharSemi  = 8'h3B;
  localparam logic [7:0] CharEqual = 8'h3D;

  localparam logic KindByte   = 1'b0;
  localparam logic KindReport = 1'b1;

  typedef enum logic [5:0] {
    ModeNormal    = 6'b000001,
    ModeAfterLf   = 6'b000010,
    ModeAfterCr   = 6'b000100,
    ModeAfterCrlf = 6'b001000,
    ModeQuote     = 6'b010000,
    ModeStopped   = 6'b100000
  } mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               kind;
    logic signed [11:0] colon_pos;
    logic               overflow;
    logic               run_last;
  } out_t;

  // Up to three results caused by one input item, packed from entry 0.
  typedef struct packed {
    logic [1:0]      num;
    out_t [2:0]      ent;
  } scan_res_t;

endpackage

// ----- hdl/mhu_scan.sv -----
// Header scanner: state registers and the per-byte unfold and compaction logic.
module mhu_scan
  import mhu_pkg::*;
#(
  parameter int unsigned MAX_HEADER_BYTES = MaxHeaderBytesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  in_t       item_i,
  output scan_res_t res_o
);

  localparam int unsigned CntW = $clog2(MAX_HEADER_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_HEADER_BYTES);

  mode_e           mode_q, mode_d, mode_s;
  logic            ws_q, ws_d, ws_s;
  logic            sep_q, sep_d, sep_s;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_s;
  logic [CntW-1:0] cpos_q, cpos_d, cpos_s;
  logic            cfound_q, cfound_d, cfound_s;
  logic            ovf_q, ovf_d, ovf_s;

  logic       req_space, req_byte, emit_space, emit_byte;
  logic [7:0] b;
  logic       blank, is_sep;
  logic [CntW-1:0] cnt_mid;
  logic [1:0] byte_idx, rep_idx, num;
  out_t       sp_ent, by_ent, rep_ent;
  out_t [2:0] ent;

  assign b      = item_i.in_byte;
  assign blank  = (b == CharSpace) || (b == CharTab);
  assign is_sep = (b == CharColon) || (b == CharSemi) || (b == CharComma) || (b == CharEqual);

  always_comb begin
    mode_s    = mode_q;
    ws_s      = ws_q;
    sep_s     = sep_q;
    cpos_s    = cpos_q;
    cfound_s  = cfound_q;
    req_space = 1'b0;
    req_byte  = 1'b0;
    case (mode_q)
      ModeNormal: begin
        if (b == CharNul) begin
          mode_s = ModeStopped;
        end else if (is_sep) begin
          ws_s  = 1'b0;
          sep_s = 1'b1;
          req_byte = 1'b1;
          if ((b == CharColon) && !cfound_q) begin
            cfound_s = 1'b1;
            cpos_s   = cnt_q;
          end
        end else if (blank) begin
          ws_s = 1'b1;
        end else if (b == CharLf) begin
          ws_s   = 1'b0;
          mode_s = ModeAfterLf;
        end else if (b == CharCr) begin
          ws_s   = 1'b0;
          mode_s = ModeAfterCr;
        end else if (b == CharQuote) begin
          ws_s     = 1'b0;
          req_byte = 1'b1;
          mode_s   = ModeQuote;
        end else begin
          if (sep_q) begin
            sep_s = 1'b0;
          end else if (ws_q) begin
            req_space = 1'b1;
          end
          ws_s     = 1'b0;
          req_byte = 1'b1;
        end
      end
      ModeAfterLf, ModeAfterCrlf: begin
        if (blank) begin
          ws_s   = 1'b1;
          mode_s = ModeNormal;
        end else begin
          mode_s = ModeStopped;
        end
      end
      ModeAfterCr: begin
        if (b == CharLf) begin
          mode_s = ModeAfterCrlf;
        end else if (blank) begin
          ws_s   = 1'b1;
          mode_s = ModeNormal;
        end else begin
          mode_s = ModeStopped;
        end
      end
      ModeQuote: begin
        if (b == CharNul) begin
          mode_s = ModeStopped;
        end else begin
          req_byte = 1'b1;
          if (b == CharQuote) begin
            mode_s = ModeNormal;
          end
        end
      end
      default: begin
        mode_s = ModeStopped;
      end
    endcase
  end

  // Bytes beyond the size limit are dropped and flagged.
  assign emit_space = req_space && (cnt_q < CntMax);
  assign cnt_mid    = cnt_q + CntW'(emit_space);
  assign emit_byte  = req_byte && (cnt_mid < CntMax);
  assign cnt_s      = cnt_mid + CntW'(emit_byte);
  assign ovf_s      = ovf_q || (req_space && !emit_space) || (req_byte && !emit_byte);

  always_comb begin
    sp_ent          = '0;
    sp_ent.out_byte = CharSpace;
    sp_ent.kind     = KindByte;
    by_ent          = '0;
    by_ent.out_byte = b;
    by_ent.kind     = KindByte;
    rep_ent         = '0;
    rep_ent.kind    = KindReport;
    rep_ent.colon_pos = cfound_s ? 12'(cpos_s) : '1;
    rep_ent.overflow = ovf_s;
  end

  assign byte_idx = {1'b0, emit_space};
  assign rep_idx  = 2'(emit_space) + 2'(emit_byte);
  assign num      = rep_idx + 2'(item_i.in_last);

  always_comb begin
    ent = '0;
    if (emit_space) begin
      ent[0] = sp_ent;
    end
    if (emit_byte) begin
      ent[byte_idx] = by_ent;
    end
    if (item_i.in_last) begin
      ent[rep_idx] = rep_ent;
    end
    if (num != 2'd0) begin
      ent[num - 2'd1].run_last = 1'b1;
    end
  end

  assign res_o.num = num;
  assign res_o.ent = ent;

  // The final byte of a header returns every state entry to its reset value.
  always_comb begin
    if (item_i.in_last) begin
      mode_d   = ModeNormal;
      ws_d     = 1'b0;
      sep_d    = 1'b0;
      cnt_d    = '0;
      cpos_d   = '0;
      cfound_d = 1'b0;
      ovf_d    = 1'b0;
    end else begin
      mode_d   = mode_s;
      ws_d     = ws_s;
      sep_d    = sep_s;
      cnt_d    = cnt_s;
      cpos_d   = cpos_s;
      cfound_d = cfound_s;
      ovf_d    = ovf_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeNormal;
      ws_q     <= 1'b0;
      sep_q    <= 1'b0;
      cnt_q    <= '0;
      cpos_q   <= '0;
      cfound_q <= 1'b0;
      ovf_q    <= 1'b0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      ws_q     <= ws_d;
      sep_q    <= sep_d;
      cnt_q    <= cnt_d;
      cpos_q   <= cpos_d;
      cfound_q <= cfound_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

// ----- hdl/mime_header_unfold_compact.sv -----
// Top level of the MIME header unfolder: scanner plus a four-entry result queue.
// A header arrives one byte per input transfer and leaves as compacted bytes on the
// output channel, followed by an end-of-header report when the input byte is marked
// last. Folded line ends (LF, CR or CRLF followed by a space or tab) are unfolded,
// whitespace around the separators colon, semicolon, comma and equals sign is
// removed, other whitespace runs shrink to one space, and quoted strings pass through
// untouched. An input byte gives zero, one, two or three results; they are written
// together into a four-entry result queue in the cycle of the input transfer and
// appear on the output from the next cycle on. The single output port drains that
// queue at one transfer per cycle while out_ready_i is high, so a byte with at most
// one result can be taken every cycle, while one with two or three results takes as
// many output transfers; the input is ready whenever the queue holds at most one result.
module mime_header_unfold_compact
  import mhu_pkg::*;
#(
  parameter int unsigned MAX_HEADER_BYTES = MaxHeaderBytesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  scan_res_t  res;
  logic       in_acc, out_acc;
  out_t       queue_q [4];
  logic [1:0] rd_ptr_q, wr_ptr_q;
  logic [2:0] cnt_q, cnt_d;

  // Three free entries are needed before a byte is taken, as it may give three results.
  assign in_ready_o  = (cnt_q <= 3'd1);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_acc     = out_valid_o && out_ready_i;
  assign out_data_o  = queue_q[rd_ptr_q];

  mhu_scan #(
    .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(in_acc),
    .item_i  (in_data_i),
    .res_o   (res)
  );

  assign cnt_d = cnt_q + (in_acc ? {1'b0, res.num} : 3'd0) - 3'(out_acc);

  // The results of one byte are written to consecutive queue entries.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (in_acc && (2'(i) < res.num)) begin
        queue_q[wr_ptr_q + 2'(i)] <= res.ent[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc) begin
        wr_ptr_q <= wr_ptr_q + res.num;
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
    end
  end

endmodule

// ----- hdl/mhu_checker.sv -----
// Port-level checker of the MIME header unfolder and its bind to the top level.
`include "assert_macros.svh"

module mhu_checker
  import mhu_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  logic rep_shown, byte_shown, byte_fields_clear;

  assign rep_shown         = out_valid_o && (out_data_o.kind == KindReport);
  assign byte_shown        = out_valid_o && (out_data_o.kind == KindByte);
  assign byte_fields_clear = (out_data_o.colon_pos == 12'sd0) && !out_data_o.overflow;

  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "output transfer withdrawn")
  `ASSERT_IMPL(a_rep_zero_byte, rep_shown, out_data_o.out_byte == 8'h00, "report carries a byte")
  `ASSERT_IMPL(a_rep_run_last, rep_shown, out_data_o.run_last, "report is not the last result")
  `ASSERT_IMPL(a_byte_clean, byte_shown, byte_fields_clear, "byte result carries report fields")

endmodule

bind mime_header_unfold_compact mhu_checker u_mhu_checker (.*);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the MIME header unfolder, with its own model of the compaction.
module tb_top;
  import mhu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The watchdog gives up after this many cycles in which neither channel moves a
  // transfer. The longest quiet stretch in a correct run is the deliberate receiver
  // hold-off of HoldCycles, so the limit leaves a wide margin.
  localparam int unsigned HoldCycles    = 60;
  localparam int unsigned QuietLimit    = 1000;
  localparam int unsigned TailCycles    = 20;
  localparam int unsigned ItemsPerPhase = 30;

  logic clk_i;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready_o;
  in_t  in_data   = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  out_t out_data_o;

  mime_header_unfold_compact #(
    .MAX_HEADER_BYTES(MaxHeaderBytesDef)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  // Header bytes waiting to be offered, and the compacted results still owed by the block.
  in_t  hdr_bytes_q[$];
  out_t compacted_q[$];

  // Phase 0: the sender rarely idles and the receiver often does. Phase 1 swaps the two.
  // Phase 2 has no random idling at all, but opens with a long receiver hold-off.
  int   phase = 0;
  logic rx_hold = 1'b0;
  logic in_taken = 1'b0;

  int unsigned errors = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_headers = 0;
  int unsigned n_colon_reports = 0;
  int unsigned n_overflow_reports = 0;
  int unsigned rand_items = 0;
  int unsigned quiet_cycles = 0;

  // Our own copy of the unfolding state for the header in progress.
  mode_e       scan_st = ModeNormal;
  logic        ws_pending = 1'b0;
  logic        after_sep = 1'b0;
  logic        colon_seen = 1'b0;
  logic        hdr_overflow = 1'b0;
  int unsigned hdr_len = 0;
  logic [11:0] colon_at = '0;

  // Results caused by the byte being modelled; at most three per byte.
  out_t        step_res[3];
  int unsigned step_n;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic is_blank(logic [7:0] b);
    return b == CharSpace || b == CharTab;
  endfunction

  function automatic logic is_separator(logic [7:0] b);
    return b == CharColon || b == CharSemi || b == CharComma || b == CharEqual;
  endfunction

  // Writes one compacted byte, unless the header has already reached the size limit,
  // in which case the byte is lost and the header is marked as overflowed.
  function automatic void emit_byte(logic [7:0] b);
    out_t r;
    if (hdr_len >= MaxHeaderBytesDef) begin
      hdr_overflow = 1'b1;
    end else begin
      r = '0;
      r.out_byte = b;
      r.kind = KindByte;
      step_res[step_n] = r;
      step_n++;
      hdr_len++;
    end
  endfunction

  function automatic void clear_header();
    scan_st = ModeNormal;
    ws_pending = 1'b0;
    after_sep = 1'b0;
    colon_seen = 1'b0;
    hdr_overflow = 1'b0;
    hdr_len = 0;
    colon_at = '0;
  endfunction

  // Works out what one accepted header byte must produce and queues it.
  function automatic void unfold_byte(in_t it);
    logic [7:0] b;
    out_t       rep;
    b = it.in_byte;
    step_n = 0;
    case (scan_st)
      ModeNormal: begin
        if (b == CharNul) begin
          scan_st = ModeStopped;
        end else if (is_separator(b)) begin
          // Whitespace in front of a separator is simply forgotten.
          ws_pending = 1'b0;
          if (b == CharColon && !colon_seen) begin
            colon_seen = 1'b1;
            colon_at = hdr_len[11:0];
          end
          after_sep = 1'b1;
          emit_byte(b);
        end else if (is_blank(b)) begin
          ws_pending = 1'b1;
        end else if (b == CharLf) begin
          ws_pending = 1'b0;
          scan_st = ModeAfterLf;
        end else if (b == CharCr) begin
          ws_pending = 1'b0;
          scan_st = ModeAfterCr;
        end else if (b == CharQuote) begin
          ws_pending = 1'b0;
          emit_byte(b);
          scan_st = ModeQuote;
        end else begin
          // A regular byte: one space stands for the whitespace run before it,
          // except straight after a separator.
          if (after_sep) begin
            after_sep = 1'b0;
          end else if (ws_pending) begin
            emit_byte(CharSpace);
          end
          ws_pending = 1'b0;
          emit_byte(b);
        end
      end
      ModeAfterLf, ModeAfterCrlf: begin
        if (is_blank(b)) begin
          ws_pending = 1'b1;
          scan_st = ModeNormal;
        end else begin
          scan_st = ModeStopped;
        end
      end
      ModeAfterCr: begin
        if (b == CharLf) begin
          scan_st = ModeAfterCrlf;
        end else if (is_blank(b)) begin
          ws_pending = 1'b1;
          scan_st = ModeNormal;
        end else begin
          scan_st = ModeStopped;
        end
      end
      ModeQuote: begin
        if (b == CharNul) begin
          scan_st = ModeStopped;
        end else begin
          emit_byte(b);
          if (b == CharQuote) scan_st = ModeNormal;
        end
      end
      default: begin
        scan_st = ModeStopped;
      end
    endcase

    if (it.in_last) begin
      rep = '0;
      rep.kind = KindReport;
      rep.colon_pos = colon_seen ? colon_at : '1;
      rep.overflow = hdr_overflow;
      step_res[step_n] = rep;
      step_n++;
      n_headers++;
      if (colon_seen) n_colon_reports++;
      if (hdr_overflow) n_overflow_reports++;
      clear_header();
    end

    if (step_n > 0) step_res[step_n - 1].run_last = 1'b1;
    for (int unsigned i = 0; i < step_n; i++) compacted_q.push_back(step_res[i]);
  endfunction

  function automatic void check_field(string what, int want_v, int got_v);
    if (want_v != got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want_v, got_v);
    end
  endfunction

  // The sender. A new header byte is only put up once the previous one has been
  // taken, so valid and the payload hold steady until the transfer happens.
  always @(negedge clk_i) begin : drive_header
    int unsigned gap_pct;
    gap_pct = (phase == 0) ? 8 : (phase == 1) ? 54 : 0;
    if (rst_ni && (!in_valid || in_taken)) begin
      if (hdr_bytes_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        in_data  <= hdr_bytes_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver. Its readiness is redrawn each cycle unless the long hold-off is on.
  always @(negedge clk_i) begin : drive_ready
    int unsigned stall_pct;
    stall_pct = (phase == 0) ? 54 : (phase == 1) ? 8 : 0;
    if (rst_ni) out_ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
  end

  // The long hold-off runs in its own process: it starts as the last phase begins,
  // while plenty of header bytes are still queued, so the block fills and pushes back.
  initial begin
    wait (phase == 2);
    @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  // Both channels are sampled at the rising edge. Results leaving the block are checked
  // before the byte accepted at the same edge is modelled, as the block only answers a
  // byte from the following cycle on.
  always @(posedge clk_i) begin : watch_ports
    out_t want;
    if (rst_ni) begin
      in_taken <= in_valid && in_ready_o;
      if (out_valid_o && out_ready) begin
        n_results++;
        if (compacted_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, got byte %0d kind %0d",
                   $realtime, out_data_o.out_byte, out_data_o.kind);
        end else begin
          want = compacted_q.pop_front();
          check_field("out_byte", want.out_byte, out_data_o.out_byte);
          check_field("kind", want.kind, out_data_o.kind);
          check_field("colon_pos", $signed(want.colon_pos),
                      $signed(out_data_o.colon_pos));
          check_field("overflow", want.overflow, out_data_o.overflow);
          check_field("run_last", want.run_last, out_data_o.run_last);
        end
      end
      if (in_valid && in_ready_o) begin
        n_items++;
        unfold_byte(in_data);
      end
    end
  end

  // Watchdog: too long without any transfer on either channel means the block has hung.
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transfer for %0d cycles, giving up", $realtime, quiet_cycles);
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic add_byte(logic [7:0] b, logic last);
    in_t it;
    it.in_byte = b;
    it.in_last = last;
    hdr_bytes_q.push_back(it);
  endtask

  task automatic printable(output logic [7:0] b);
    b = 8'($urandom_range(8'h21, 8'h7E));
  endtask

  // One random header. Most of it is well-formed material (words, whitespace,
  // separators, quoted strings and folds), with the odd hard line end, zero byte
  // or arbitrary byte mixed in.
  task automatic rand_header();
    logic [7:0] hb[$];
    logic [7:0] b;
    int unsigned len;
    int unsigned pick;
    len = $urandom_range(1, 18);
    while (hb.size() < len) begin
      pick = $urandom_range(99);
      if (pick < 44) begin
        printable(b);
        hb.push_back(b);
      end else if (pick < 58) begin
        hb.push_back($urandom_range(1) ? CharSpace : CharTab);
      end else if (pick < 68) begin
        case ($urandom_range(3))
          0: hb.push_back(CharColon);
          1: hb.push_back(CharSemi);
          2: hb.push_back(CharComma);
          default: hb.push_back(CharEqual);
        endcase
      end else if (pick < 76) begin
        hb.push_back(CharQuote);
        repeat ($urandom_range(0, 4)) begin
          b = 8'($urandom_range(8'h20, 8'h7E));
          hb.push_back(b);
        end
        if ($urandom_range(9) != 0) hb.push_back(CharQuote);
      end else if (pick < 87) begin
        case ($urandom_range(2))
          0: hb.push_back(CharLf);
          1: hb.push_back(CharCr);
          default: begin
            hb.push_back(CharCr);
            hb.push_back(CharLf);
          end
        endcase
        hb.push_back($urandom_range(1) ? CharSpace : CharTab);
      end else if (pick < 90) begin
        hb.push_back($urandom_range(1) ? CharLf : CharCr);
        printable(b);
        hb.push_back(b);
      end else if (pick < 92) begin
        hb.push_back(CharNul);
      end else begin
        b = 8'($urandom_range(255));
        hb.push_back(b);
      end
    end
    for (int unsigned i = 0; i < hb.size(); i++) add_byte(hb[i], i == hb.size() - 1);
    rand_items += hb.size();
  endtask

  task automatic drain();
    while (hdr_bytes_q.size() != 0 || in_valid || compacted_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Collapsed whitespace, separators with and without blanks around them, a blank before a
    // quote, a quoted space, and a word straight after a quote that followed a separator.
    add_byte("K", 1'b0);
    add_byte(CharSpace, 1'b0);
    add_byte(CharColon, 1'b0);
    add_byte(CharTab, 1'b0);
    add_byte("v", 1'b0);
    add_byte(CharSpace, 1'b0);
    add_byte("x", 1'b0);
    add_byte(CharSemi, 1'b0);
    add_byte(CharEqual, 1'b0);
    add_byte(CharSpace, 1'b0);
    add_byte(CharQuote, 1'b0);
    add_byte(CharSpace, 1'b0);
    add_byte(CharQuote, 1'b0);
    add_byte("w", 1'b1);
    // A CRLF fold, an LF fold, a zero inside a quoted string, then an all-ones byte
    // that arrives after the stop and only closes the header.
    add_byte("a", 1'b0);
    add_byte(CharCr, 1'b0);
    add_byte(CharLf, 1'b0);
    add_byte(CharSpace, 1'b0);
    add_byte(CharComma, 1'b0);
    add_byte(CharLf, 1'b0);
    add_byte(CharTab, 1'b0);
    add_byte(CharQuote, 1'b0);
    add_byte("z", 1'b0);
    add_byte(CharNul, 1'b0);
    add_byte(8'hFF, 1'b1);
    // A bare CR fold, then a line end on the final byte; then a header that is just a zero.
    add_byte("b", 1'b0);
    add_byte(CharCr, 1'b0);
    add_byte(CharTab, 1'b0);
    add_byte("c", 1'b0);
    add_byte(CharCr, 1'b1);
    add_byte(CharNul, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      int unsigned goal;
      phase = ph;
      goal = rand_items + ItemsPerPhase;
      while (rand_items < goal) rand_header();
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);
    $display("Covered %0d headers: %0d byte transfers in, %0d result transfers out.",
             n_headers, n_items, n_results);
    $display("Reports with a colon: %0d, reports with overflow: %0d, errors: %0d.",
             n_colon_reports, n_overflow_reports, errors);
    if (errors == 0 && compacted_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
